/* design/asbb_pkg.sv */
// Shared constants for the annular sector bounding box datapath.
package asbb_pkg;

    localparam int unsigned RADIUS_BITS = 22;
    localparam int unsigned ANGLE_BITS  = 15;
    localparam int unsigned ANGLE_FRAC  = 6;

    localparam int unsigned ANG_QUARTER = 90 << ANGLE_FRAC;
    localparam int unsigned ANG_FULL    = 360 << ANGLE_FRAC;
    localparam int unsigned ANG_HALF    = (1 << ANGLE_FRAC) >> 1;
    localparam int unsigned END_BITS    = $clog2(2 * ANG_FULL);
    localparam int unsigned PHI_BITS    = $clog2(ANG_QUARTER + 1);

    // Q1.30 constants of the sine series
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
    localparam int unsigned     Q30_BITS        = 31;
    localparam logic [30:0]     ONE_Q30         = 31'h4000_0000;
    localparam int unsigned     TRIG_BITS       = 16;
    localparam logic [15:0]     TRIG_ONE        = 16'h8000;

    localparam int unsigned SINE_ITERS  = 5;
    localparam int unsigned SINE_STAGES = 2 + 2 * SINE_ITERS + 2;

    // Horner divisors, and shift for an exact reciprocal of a 32-bit dividend
    localparam int unsigned SINE_DIV   [SINE_ITERS] = '{110, 72, 42, 20, 6};
    localparam int unsigned SINE_SHIFT [SINE_ITERS] = '{39, 39, 38, 37, 35};

endpackage

/* design/asbb_if.sv */
// Word channels of the bounding box block: wedge in, box out.
interface asbb_wedge_if
    import asbb_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [RADIUS_BITS-1:0]       radius_inner;
    logic [RADIUS_BITS-1:0]       radius_outer;
    logic [ANGLE_BITS-1:0]        angle_start;
    logic [ANGLE_BITS-1:0]        angle_end;

    modport source (
        output valid, center_x, center_y, radius_inner, radius_outer,
               angle_start, angle_end,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, radius_inner, radius_outer,
               angle_start, angle_end,
        output ready
    );
endinterface

interface asbb_box_if
#(
    parameter int COORD_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] box_x_min;
    logic signed [COORD_BITS:0] box_x_max;
    logic signed [COORD_BITS:0] box_y_min;
    logic signed [COORD_BITS:0] box_y_max;

    modport source (
        output valid, box_x_min, box_x_max, box_y_min, box_y_max,
        input  ready
    );
    modport sink (
        input  valid, box_x_min, box_x_max, box_y_min, box_y_max,
        output ready
    );
endinterface

/* design/asbb_sine.sv */
// Pipelined first-quadrant sine: Taylor series in Horner form, Q2.30, Q1.15 out.
module asbb_sine
    import asbb_pkg::*;
(
    input  logic                   clk,
    input  logic [SINE_STAGES-1:0] en,
    input  logic [PHI_BITS-1:0]    t,
    output logic [TRIG_BITS-1:0]   sin
);

    logic [Q30_BITS-1:0] x0_reg;
    logic [Q30_BITS-1:0] x1_reg;
    logic [31:0]         x2_1_reg;

    logic [Q30_BITS-1:0] xa_reg  [SINE_ITERS];
    logic [Q30_BITS-1:0] xb_reg  [SINE_ITERS];
    logic [31:0]         x2a_reg [SINE_ITERS];
    logic [31:0]         x2b_reg [SINE_ITERS];
    logic [31:0]         m_reg   [SINE_ITERS];
    logic [Q30_BITS-1:0] p_reg   [SINE_ITERS];

    logic [Q30_BITS-1:0] s_reg;
    logic [TRIG_BITS-1:0] sin_reg;
    logic [16:0]          s_round;

    // angle to radians, then x squared
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg <= Q30_BITS'((38'(t) * 38'(RAD_PER_DEG_Q30) + 38'(ANG_HALF))
                                >> ANGLE_FRAC);
        end
        if (en[1])
        begin
            x1_reg   <= x0_reg;
            x2_1_reg <= 32'((62'(x0_reg) * 62'(x0_reg)) >> 30);
        end
    end

    for (genvar i = 0; i < SINE_ITERS; i++)
    begin : g_iter
        localparam int unsigned K     = SINE_SHIFT[i];
        localparam logic [32:0] RECIP =
            33'(((65'd1 << K) + 65'(SINE_DIV[i]) - 65'd1) / 65'(SINE_DIV[i]));

        logic [Q30_BITS-1:0] x_in;
        logic [31:0]         x2_in;
        logic [Q30_BITS-1:0] p_in;
        logic [31:0]         q;

        if (i == 0)
        begin : g_first
            assign x_in  = x1_reg;
            assign x2_in = x2_1_reg;
            assign p_in  = ONE_Q30;
        end
        else
        begin : g_next
            assign x_in  = xb_reg[i-1];
            assign x2_in = x2b_reg[i-1];
            assign p_in  = p_reg[i-1];
        end

        // exact quotient by multiply with a rounded-up reciprocal
        assign q = 32'((65'(m_reg[i]) * 65'(RECIP)) >> K);

        always_ff @(posedge clk)
        begin
            if (en[2 + 2*i])
            begin
                m_reg[i]   <= 32'((63'(x2_in) * 63'(p_in)) >> 30);
                xa_reg[i]  <= x_in;
                x2a_reg[i] <= x2_in;
            end
            if (en[3 + 2*i])
            begin
                p_reg[i]   <= ONE_Q30 - Q30_BITS'(q);
                xb_reg[i]  <= xa_reg[i];
                x2b_reg[i] <= x2a_reg[i];
            end
        end
    end

    assign s_round = 17'((32'(s_reg) + 32'd16384) >> 15);

    always_ff @(posedge clk)
    begin
        if (en[SINE_STAGES-2])
        begin
            s_reg <= Q30_BITS'((62'(xb_reg[SINE_ITERS-1]) * 62'(p_reg[SINE_ITERS-1]))
                               >> 30);
        end
        if (en[SINE_STAGES-1])
        begin
            sin_reg <= (s_round > 17'(TRIG_ONE)) ? TRIG_ONE : s_round[TRIG_BITS-1:0];
        end
    end

    assign sin = sin_reg;

endmodule

/* design/annular_sector_bounding_box_core.sv */
// Axis-aligned bounding box of a wedge (annular sector), fully pipelined.
// One wedge word is taken per clock while some stage has room, and one box
// word comes out per wedge, in order, through 20 register stages. Headings
// are compass bearings in 1/64 degree units, clockwise from north; both are
// reduced modulo 360 degrees, and an inner radius above the outer is clamped.
// The four corner points are projected with Q1.15 sine/cosine (a 14-stage
// Taylor/Horner pipeline, four copies) and rounded to nearest; the box is
// their min/max, widened to center +/- outer radius on each compass axis the
// clockwise arc crosses. Each stage holds a valid bit and advances whenever
// the stage after it is empty or moving, so bubbles close up under a stall
// and input is taken as long as any stage has room.
module annular_sector_bounding_box_core
    import asbb_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    asbb_wedge_if.sink   wedge,
    asbb_box_if.source   box
);

    localparam int unsigned NSTG    = 2 + SINE_STAGES + 4;
    localparam int unsigned SIN_END = 1 + SINE_STAGES;       // stage of sine result
    localparam int unsigned SW      =
        ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    typedef struct packed {
        logic north;
        logic east;
        logic south;
        logic west;
    } cross_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [RADIUS_BITS-1:0]       rlo;
        logic [RADIUS_BITS-1:0]       rhi;
        logic [1:0]                   ql;
        logic [1:0]                   qh;
        cross_t                       axes;
    } side_t;

    // ---------------- stage control ----------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] load;

    always_comb
    begin
        load[NSTG-1] = !v_reg[NSTG-1] || box.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k] = !v_reg[k] || load[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                v_reg[0] <= wedge.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (load[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign wedge.ready = load[0];
    assign box.valid   = v_reg[NSTG-1];

    // ---------------- stage 0: reduce headings, clamp radius ----------------
    logic signed [COORD_BITS-1:0] cx0_reg, cy0_reg;
    logic [RADIUS_BITS-1:0]       rlo0_reg, rhi0_reg;
    logic [ANGLE_BITS-1:0]        la0_reg, ha0_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            cx0_reg  <= wedge.center_x;
            cy0_reg  <= wedge.center_y;
            rhi0_reg <= wedge.radius_outer;
            rlo0_reg <= (wedge.radius_inner > wedge.radius_outer) ?
                        wedge.radius_outer : wedge.radius_inner;
            la0_reg  <= (wedge.angle_start >= ANGLE_BITS'(ANG_FULL)) ?
                        wedge.angle_start - ANGLE_BITS'(ANG_FULL) : wedge.angle_start;
            ha0_reg  <= (wedge.angle_end >= ANGLE_BITS'(ANG_FULL)) ?
                        wedge.angle_end - ANGLE_BITS'(ANG_FULL) : wedge.angle_end;
        end
    end

    // ---------------- stage 1: quadrants, sine arguments, axis crossings ----
    logic [END_BITS-1:0] la_e, ha_e, arc_end;
    logic [1:0]          ql_c, qh_c;
    logic [PHI_BITS-1:0] phil_c, phih_c;
    cross_t              cross_c;

    function automatic logic [1:0] quad_of(input logic [ANGLE_BITS-1:0] a);
        logic [1:0] q;
        if (a >= ANGLE_BITS'(3 * ANG_QUARTER))
            q = 2'd3;
        else if (a >= ANGLE_BITS'(2 * ANG_QUARTER))
            q = 2'd2;
        else if (a >= ANGLE_BITS'(ANG_QUARTER))
            q = 2'd1;
        else
            q = 2'd0;
        return q;
    endfunction

    function automatic logic [PHI_BITS-1:0] phi_of(input logic [ANGLE_BITS-1:0] a,
                                                   input logic [1:0] q);
        logic [ANGLE_BITS-1:0] base;
        case (q)
            2'd0:    base = '0;
            2'd1:    base = ANGLE_BITS'(ANG_QUARTER);
            2'd2:    base = ANGLE_BITS'(2 * ANG_QUARTER);
            default: base = ANGLE_BITS'(3 * ANG_QUARTER);
        endcase
        return PHI_BITS'(a - base);
    endfunction

    always_comb
    begin
        la_e    = END_BITS'(la0_reg);
        ha_e    = END_BITS'(ha0_reg);
        // end of the clockwise arc: start + ((end - start) mod 360)
        arc_end = (ha_e >= la_e) ? ha_e : ha_e + END_BITS'(ANG_FULL);
        ql_c    = quad_of(la0_reg);
        qh_c    = quad_of(ha0_reg);
        phil_c  = phi_of(la0_reg, ql_c);
        phih_c  = phi_of(ha0_reg, qh_c);

        cross_c.north = arc_end >= END_BITS'(4 * ANG_QUARTER);
        cross_c.east  = (la_e < END_BITS'(ANG_QUARTER) && arc_end > END_BITS'(ANG_QUARTER))
                     || (la_e > END_BITS'(ANG_QUARTER) && arc_end > END_BITS'(5 * ANG_QUARTER));
        cross_c.south = (la_e < END_BITS'(2 * ANG_QUARTER)
                         && arc_end > END_BITS'(2 * ANG_QUARTER))
                     || (la_e > END_BITS'(2 * ANG_QUARTER)
                         && arc_end > END_BITS'(6 * ANG_QUARTER));
        cross_c.west  = (la_e < END_BITS'(3 * ANG_QUARTER)
                         && arc_end > END_BITS'(3 * ANG_QUARTER))
                     || (la_e > END_BITS'(3 * ANG_QUARTER)
                         && arc_end > END_BITS'(7 * ANG_QUARTER));
    end

    side_t               sb1_reg;
    logic [PHI_BITS-1:0] tls1_reg, tlc1_reg, ths1_reg, thc1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            sb1_reg.cx    <= cx0_reg;
            sb1_reg.cy    <= cy0_reg;
            sb1_reg.rlo   <= rlo0_reg;
            sb1_reg.rhi   <= rhi0_reg;
            sb1_reg.ql    <= ql_c;
            sb1_reg.qh    <= qh_c;
            sb1_reg.axes  <= cross_c;
            tls1_reg      <= phil_c;
            tlc1_reg      <= PHI_BITS'(ANG_QUARTER) - phil_c;
            ths1_reg      <= phih_c;
            thc1_reg      <= PHI_BITS'(ANG_QUARTER) - phih_c;
        end
    end

    // ---------------- stages 2..15: sine pipelines ----------------
    logic [SINE_STAGES-1:0] sine_en;
    logic [TRIG_BITS-1:0]   sin_ls, sin_lc, sin_hs, sin_hc;

    assign sine_en = load[SIN_END:2];

    asbb_sine u_sine_ls (.clk(clk), .en(sine_en), .t(tls1_reg), .sin(sin_ls));
    asbb_sine u_sine_lc (.clk(clk), .en(sine_en), .t(tlc1_reg), .sin(sin_lc));
    asbb_sine u_sine_hs (.clk(clk), .en(sine_en), .t(ths1_reg), .sin(sin_hs));
    asbb_sine u_sine_hc (.clk(clk), .en(sine_en), .t(thc1_reg), .sin(sin_hc));

    side_t sb_reg [SINE_STAGES];

    for (genvar j = 0; j < SINE_STAGES; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (load[2 + j])
            begin
                sb_reg[j] <= (j == 0) ? sb1_reg : sb_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---------------- stage 16: quadrant fold and radius scaling ----------
    // corner order: inner/start, outer/start, inner/end, outer/end
    side_t                  sbl;
    logic [TRIG_BITS-1:0]   mag_x [4];
    logic [TRIG_BITS-1:0]   mag_y [4];
    logic [3:0]             neg_x_c, neg_y_c;
    logic [RADIUS_BITS-1:0] r_c   [4];

    always_comb
    begin
        sbl        = sb_reg[SINE_STAGES-1];
        mag_x[0]   = sbl.ql[0] ? sin_lc : sin_ls;
        mag_y[0]   = sbl.ql[0] ? sin_ls : sin_lc;
        mag_x[2]   = sbl.qh[0] ? sin_hc : sin_hs;
        mag_y[2]   = sbl.qh[0] ? sin_hs : sin_hc;
        mag_x[1]   = mag_x[0];
        mag_y[1]   = mag_y[0];
        mag_x[3]   = mag_x[2];
        mag_y[3]   = mag_y[2];
        neg_x_c[0] = sbl.ql[1];
        neg_y_c[0] = sbl.ql[1] ^ sbl.ql[0];
        neg_x_c[2] = sbl.qh[1];
        neg_y_c[2] = sbl.qh[1] ^ sbl.qh[0];
        neg_x_c[1] = neg_x_c[0];
        neg_y_c[1] = neg_y_c[0];
        neg_x_c[3] = neg_x_c[2];
        neg_y_c[3] = neg_y_c[2];
        r_c[0]     = sbl.rlo;
        r_c[1]     = sbl.rhi;
        r_c[2]     = sbl.rlo;
        r_c[3]     = sbl.rhi;
    end

    localparam int unsigned PW = RADIUS_BITS + TRIG_BITS;

    logic [RADIUS_BITS-1:0]       dx16_reg [4];
    logic [RADIUS_BITS-1:0]       dy16_reg [4];
    logic [3:0]                   negx16_reg, negy16_reg;
    logic signed [COORD_BITS-1:0] cx16_reg, cy16_reg;
    logic [RADIUS_BITS-1:0]       rhi16_reg;
    cross_t                       cross16_reg;

    always_ff @(posedge clk)
    begin
        if (load[SIN_END+1])
        begin
            for (int c = 0; c < 4; c++)
            begin
                // round(r * trig / 2^15), magnitude only; sign applied later
                dx16_reg[c] <= RADIUS_BITS'((PW'(r_c[c]) * PW'(mag_x[c]) + PW'(16384))
                                            >> 15);
                dy16_reg[c] <= RADIUS_BITS'((PW'(r_c[c]) * PW'(mag_y[c]) + PW'(16384))
                                            >> 15);
            end
            negx16_reg  <= neg_x_c;
            negy16_reg  <= neg_y_c;
            cx16_reg    <= sbl.cx;
            cy16_reg    <= sbl.cy;
            rhi16_reg   <= sbl.rhi;
            cross16_reg <= sbl.axes;
        end
    end

    // ---------------- stage 17: corner points ----------------
    logic signed [SW-1:0] px17_reg [4];
    logic signed [SW-1:0] py17_reg [4];
    logic signed [SW-1:0] cx17_reg, cy17_reg;
    logic signed [SW-1:0] rhi17_reg;
    cross_t               cross17_reg;
    logic signed [SW-1:0] cx16_e, cy16_e;

    assign cx16_e = SW'(cx16_reg);
    assign cy16_e = SW'(cy16_reg);

    always_ff @(posedge clk)
    begin
        if (load[SIN_END+2])
        begin
            for (int c = 0; c < 4; c++)
            begin
                px17_reg[c] <= negx16_reg[c] ? cx16_e - $signed(SW'(dx16_reg[c]))
                                             : cx16_e + $signed(SW'(dx16_reg[c]));
                py17_reg[c] <= negy16_reg[c] ? cy16_e - $signed(SW'(dy16_reg[c]))
                                             : cy16_e + $signed(SW'(dy16_reg[c]));
            end
            cx17_reg    <= cx16_e;
            cy17_reg    <= cy16_e;
            rhi17_reg   <= $signed(SW'(rhi16_reg));
            cross17_reg <= cross16_reg;
        end
    end

    // ---------------- stage 18: pairwise min/max ----------------
    logic signed [SW-1:0] xlo18_reg [2];
    logic signed [SW-1:0] xhi18_reg [2];
    logic signed [SW-1:0] ylo18_reg [2];
    logic signed [SW-1:0] yhi18_reg [2];
    logic signed [SW-1:0] cx18_reg, cy18_reg, rhi18_reg;
    cross_t               cross18_reg;

    always_ff @(posedge clk)
    begin
        if (load[SIN_END+3])
        begin
            for (int h = 0; h < 2; h++)
            begin
                xlo18_reg[h] <= (px17_reg[2*h+1] < px17_reg[2*h]) ?
                                px17_reg[2*h+1] : px17_reg[2*h];
                xhi18_reg[h] <= (px17_reg[2*h+1] > px17_reg[2*h]) ?
                                px17_reg[2*h+1] : px17_reg[2*h];
                ylo18_reg[h] <= (py17_reg[2*h+1] < py17_reg[2*h]) ?
                                py17_reg[2*h+1] : py17_reg[2*h];
                yhi18_reg[h] <= (py17_reg[2*h+1] > py17_reg[2*h]) ?
                                py17_reg[2*h+1] : py17_reg[2*h];
            end
            cx18_reg    <= cx17_reg;
            cy18_reg    <= cy17_reg;
            rhi18_reg   <= rhi17_reg;
            cross18_reg <= cross17_reg;
        end
    end

    // ---------------- stage 19: final box and axis widening ----------------
    logic signed [SW-1:0] xmin_c, xmax_c, ymin_c, ymax_c;

    always_comb
    begin
        xmin_c = (xlo18_reg[1] < xlo18_reg[0]) ? xlo18_reg[1] : xlo18_reg[0];
        xmax_c = (xhi18_reg[1] > xhi18_reg[0]) ? xhi18_reg[1] : xhi18_reg[0];
        ymin_c = (ylo18_reg[1] < ylo18_reg[0]) ? ylo18_reg[1] : ylo18_reg[0];
        ymax_c = (yhi18_reg[1] > yhi18_reg[0]) ? yhi18_reg[1] : yhi18_reg[0];
        if (cross18_reg.north)
            ymax_c = cy18_reg + rhi18_reg;
        if (cross18_reg.east)
            xmax_c = cx18_reg + rhi18_reg;
        if (cross18_reg.south)
            ymin_c = cy18_reg - rhi18_reg;
        if (cross18_reg.west)
            xmin_c = cx18_reg - rhi18_reg;
    end

    logic signed [COORD_BITS:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;

    always_ff @(posedge clk)
    begin
        if (load[NSTG-1])
        begin
            xmin_reg <= xmin_c[COORD_BITS:0];
            xmax_reg <= xmax_c[COORD_BITS:0];
            ymin_reg <= ymin_c[COORD_BITS:0];
            ymax_reg <= ymax_c[COORD_BITS:0];
        end
    end

    assign box.box_x_min = xmin_reg;
    assign box.box_x_max = xmax_reg;
    assign box.box_y_min = ymin_reg;
    assign box.box_y_max = ymax_reg;

    // ---------------- checks ----------------
    // a full pipe under output stall must refuse new words
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg && !box.ready) |-> !wedge.ready)
        else $error("wedge taken with pipe full and output stalled");

    // a stalled result must not be overwritten by the stage behind it
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (box.valid && !box.ready) |=> (box.valid && $stable(xmin_reg)
                                       && $stable(ymax_reg)))
        else $error("stalled box word changed");

    // a valid box never has a min edge above its max edge
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid |-> (box.box_x_min <= box.box_x_max
                       && box.box_y_min <= box.box_y_max))
        else $error("box edges out of order");

endmodule
